>>> rtl/assert_macros.svh
// assertion macros shared by the equalizer rtl
// each macro expects clk and rst_n in scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on the same clock edge as the trigger
`define SVEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold on the clock after the trigger
`define SVEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sveq_pkg.sv
// shared types and constants for the stereo three-band state-variable equalizer
// used by sveq_ctrl, sveq_lane, sveq_datapath and stereo_svf_three_band_eq
package sveq_pkg;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int CH_W    = 5;
  localparam int COEF_W  = 24;
  localparam int GAIN_W  = 17;
  localparam int STATE_W = 32;

  // internal arithmetic widths
  localparam int SUM_W       = STATE_W + 2;                // sum of three states
  localparam int CPROD_W     = COEF_W + 1 + STATE_W;       // coef times state
  localparam int WPROD_W     = SUM_W + GAIN_W + 1;         // sum times gain
  localparam int TOT_W       = WPROD_W + 2;                // three weighted terms
  localparam int ROUND_SHIFT = COEF_W;                     // Q0.24 product scaling
  localparam int AVG_SHIFT   = 16;                         // Q1.16 gain scaling
  localparam int T_W         = TOT_W - AVG_SHIFT;
  localparam int AVG_HALF    = 98304;                      // half of 3 * 2^16

  // configuration port
  localparam int          CFG_ADDR_W    = 3;
  localparam int          CFG_DATA_W    = 32;
  localparam logic [0:0]  REG_FREQ_COEF = 1'b0;
  localparam logic [COEF_W-1:0] COEF_RESET = 24'd435738;

  // datapath operations, one per cycle; the finish step waits while the output register is full
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_B,
    OP_LP,
    OP_HP,
    OP_MUL_H,
    OP_BP,
    OP_STORE,
    OP_WH,
    OP_WM,
    OP_WL,
    OP_WEND,
    OP_ROUND,
    OP_CLAMP,
    OP_DIV,
    OP_FIN
  } sveq_op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_B,
    ST_LP,
    ST_HP,
    ST_MUL_H,
    ST_BP,
    ST_STORE,
    ST_WH,
    ST_WM,
    ST_WL,
    ST_WEND,
    ST_ROUND,
    ST_CLAMP,
    ST_DIV,
    ST_FIN
  } sveq_state_t;

  // controller to datapath
  typedef struct packed {
    logic     take;      // input word accepted this cycle
    sveq_op_t op;
    logic     acc_band;  // fold previous pass band output into its sum
  } sveq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
  } sveq_status_t;

endpackage

>>> rtl/sveq_ctrl.sv
// sequencer for the equalizer: steps the datapath through three filter passes,
// the weighting and the final scaling; depends on sveq_pkg
module sveq_ctrl
  import sveq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  sveq_status_t status,
  output sveq_cmd_t    cmd
);

  sveq_state_t state_r, state_nxt;
  logic [1:0]  pass_r, pass_nxt;

  // state and pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        pass_nxt  = 2'd0;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: state_nxt = ST_LP;
      ST_LP:    state_nxt = ST_HP;
      ST_HP:    state_nxt = ST_MUL_H;
      ST_MUL_H: state_nxt = ST_BP;
      ST_BP: begin
        pass_nxt = pass_r + 2'd1;
        if (pass_r == 2'd2) state_nxt = ST_STORE;
        else state_nxt = ST_MUL_B;
      end
      ST_STORE: state_nxt = ST_WH;
      ST_WH:    state_nxt = ST_WM;
      ST_WM:    state_nxt = ST_WL;
      ST_WL:    state_nxt = ST_WEND;
      ST_WEND:  state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_tready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.acc_band = (pass_r != 2'd0);
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_LOAD:  cmd.op = OP_LOAD;
      ST_MUL_B: cmd.op = OP_MUL_B;
      ST_LP:    cmd.op = OP_LP;
      ST_HP:    cmd.op = OP_HP;
      ST_MUL_H: cmd.op = OP_MUL_H;
      ST_BP:    cmd.op = OP_BP;
      ST_STORE: cmd.op = OP_STORE;
      ST_WH:    cmd.op = OP_WH;
      ST_WM:    cmd.op = OP_WM;
      ST_WL:    cmd.op = OP_WL;
      ST_WEND:  cmd.op = OP_WEND;
      ST_ROUND: cmd.op = OP_ROUND;
      ST_CLAMP: cmd.op = OP_CLAMP;
      ST_DIV:   cmd.op = OP_DIV;
      ST_FIN: begin
        if (status.out_free) cmd.op = OP_FIN;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/sveq_lane.sv
// one side of the equalizer: state-variable filter passes on a shared
// coefficient multiplier, gain weighting and divide by three; depends on sveq_pkg
module sveq_lane
  import sveq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  sveq_cmd_t                     cmd,
  input  logic        [COEF_W-1:0]      coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [GAIN_W-1:0]      high_gain,
  input  logic        [GAIN_W-1:0]      mid_gain,
  input  logic        [GAIN_W-1:0]      low_gain,
  input  logic signed [STATE_W-1:0]     lp_init,
  input  logic signed [STATE_W-1:0]     bp_init,
  output logic signed [STATE_W-1:0]     lp_q,
  output logic signed [STATE_W-1:0]     bp_q,
  output logic        [SAMPLE_BITS-1:0] y
);

  localparam int    UW    = SAMPLE_BITS + 2;
  localparam longint LO3  = -(longint'(3) <<< (SAMPLE_BITS - 1));
  localparam logic signed [T_W-1:0] T_LO = T_W'(LO3);
  localparam logic signed [T_W-1:0] T_HI = T_W'(-LO3 - 1);
  localparam logic [UW-1:0] U_MAX = UW'(-2 * LO3 - 1);
  // reciprocal of three, exact for any value below 2^UW
  localparam logic [UW-1:0] RECIP = UW'(((64'd1 << (UW + 1)) + 64'd2) / 64'd3);
  localparam logic signed [CPROD_W-1:0] RND_HALF = CPROD_W'(64'd1 << (ROUND_SHIFT - 1));

  logic signed [STATE_W-1:0]   lp_r, bp_r, hp_r;
  logic signed [CPROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]     sl_r, sb_r, sh_r;
  logic signed [WPROD_W-1:0]   wprod_r;
  logic signed [TOT_W-1:0]     tot_r;
  logic signed [T_W-1:0]       t_r;
  logic        [UW-1:0]        u_r;
  logic        [2*UW-1:0]      dprod_r;

  logic signed [STATE_W-1:0]   cmul_in;
  logic signed [CPROD_W-1:0]   cprod;
  logic signed [CPROD_W-1:0]   prod_rnd;
  logic signed [CPROD_W-ROUND_SHIFT-1:0] rnd_v;
  logic signed [STATE_W+1:0]   lp_sum, hp_sum, bp_sum;
  logic signed [SUM_W-1:0]     w_sum;
  logic        [GAIN_W-1:0]    w_gain;
  logic signed [WPROD_W-1:0]   wprod;
  logic signed [TOT_W-1:0]     tot_rnd;
  logic signed [T_W-1:0]       t_off;
  logic        [SAMPLE_BITS-1:0] q;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [STATE_W+1:0] v);
    logic signed [STATE_W-1:0] r;
    if ((v[STATE_W+1] == v[STATE_W]) && (v[STATE_W] == v[STATE_W-1])) begin
      r = v[STATE_W-1:0];
    end else if (v[STATE_W+1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // coefficient multiplier, shared by both multiplies of every pass
  assign cmul_in  = (cmd.op == OP_MUL_B) ? bp_r : hp_r;
  assign cprod    = $signed({1'b0, coef}) * cmul_in;
  assign prod_rnd = prod_r + RND_HALF;
  assign rnd_v    = prod_rnd[CPROD_W-1:ROUND_SHIFT];

  // filter sums before saturation
  assign lp_sum = (STATE_W+2)'(lp_r) + (STATE_W+2)'(rnd_v);
  assign hp_sum = (STATE_W+2)'(x) - (STATE_W+2)'(lp_r) - (STATE_W+2)'(bp_r);
  assign bp_sum = (STATE_W+2)'(bp_r) + (STATE_W+2)'(rnd_v);

  // gain multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_WH: begin
        w_sum  = sh_r;
        w_gain = high_gain;
      end
      OP_WM: begin
        w_sum  = sb_r;
        w_gain = mid_gain;
      end
      default: begin
        w_sum  = sl_r;
        w_gain = low_gain;
      end
    endcase
  end

  assign wprod   = w_sum * $signed({1'b0, w_gain});
  assign tot_rnd = tot_r + TOT_W'(AVG_HALF);
  assign t_off   = t_r - T_LO;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        lp_r <= lp_init;
        bp_r <= bp_init;
        sl_r <= '0;
        sb_r <= '0;
        sh_r <= '0;
      end
      OP_MUL_B: begin
        prod_r <= cprod;
        if (cmd.acc_band) sb_r <= sb_r + SUM_W'(bp_r);
      end
      OP_LP: lp_r <= sat_state(lp_sum);
      OP_HP: begin
        hp_r <= sat_state(hp_sum);
        sl_r <= sl_r + SUM_W'(lp_r);
      end
      OP_MUL_H: begin
        prod_r <= cprod;
        sh_r   <= sh_r + SUM_W'(hp_r);
      end
      OP_BP:    bp_r <= sat_state(bp_sum);
      OP_STORE: sb_r <= sb_r + SUM_W'(bp_r);
      OP_WH:    wprod_r <= wprod;
      OP_WM: begin
        tot_r   <= TOT_W'(wprod_r);
        wprod_r <= wprod;
      end
      OP_WL: begin
        tot_r   <= tot_r + TOT_W'(wprod_r);
        wprod_r <= wprod;
      end
      OP_WEND:  tot_r <= tot_r + TOT_W'(wprod_r);
      OP_ROUND: t_r <= tot_rnd[TOT_W-1:AVG_SHIFT];
      // clamp to the range whose third fits the sample, then offset to positive
      OP_CLAMP: begin
        if (t_r < T_LO) u_r <= '0;
        else if (t_r > T_HI) u_r <= U_MAX;
        else u_r <= t_off[UW-1:0];
      end
      OP_DIV:   dprod_r <= u_r * RECIP;
      default: begin
      end
    endcase
  end

  // quotient, shifted back by the offset (flip of the sign bit)
  assign q    = dprod_r[UW+SAMPLE_BITS:UW+1];
  assign y    = {~q[SAMPLE_BITS-1], q[SAMPLE_BITS-2:0]};
  assign lp_q = lp_r;
  assign bp_q = bp_r;

endmodule

>>> rtl/sveq_datapath.sv
// equalizer datapath: input and output registers, per-channel state memory
// and the left and right lanes; depends on sveq_pkg and sveq_lane
module sveq_datapath
  import sveq_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sveq_cmd_t                cmd,
  output sveq_status_t             status,
  input  logic [COEF_W-1:0]        coef,
  input  logic [CH_W-1:0]          in_tuser,
  input  logic [((2*SAMPLE_BITS+3*GAIN_W+7)/8)*8-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [CH_W-1:0]          out_tuser,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W  = 4 * STATE_W;
  localparam int OUT_DW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int SB     = SAMPLE_BITS;

  logic [IW-1:0] slot_tbl [2**CH_W];
  logic [IW-1:0] rd_slot;

  logic [CH_W-1:0]        ch_r;
  logic [IW-1:0]          slot_r;
  logic signed [SB-1:0]   xl_r, xr_r;
  logic [GAIN_W-1:0]      hg_r, mg_r, lg_r;

  logic [ROW_W-1:0]       mem [CHANNELS];
  logic [ROW_W-1:0]       rd_r;
  logic [CHANNELS-1:0]    valid_r;
  logic                   rd_valid_r;
  logic [ROW_W-1:0]       rd_row;

  logic signed [STATE_W-1:0] lp_l, bp_l, lp_rt, bp_rt;
  logic [SB-1:0]             y_l, y_rt;

  logic                      out_valid_r;
  logic [CH_W-1:0]           out_ch_r;
  logic [SB-1:0]             out_l_r, out_rt_r;

  // channel to state row, wrapping beyond the channel count
  for (genvar g = 0; g < 2**CH_W; g++) begin : g_slot
    assign slot_tbl[g] = IW'(g % CHANNELS);
  end
  assign rd_slot = slot_tbl[in_tuser];

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r   <= in_tuser;
      slot_r <= rd_slot;
      xl_r   <= in_tdata[SB-1:0];
      xr_r   <= in_tdata[2*SB-1:SB];
      hg_r   <= in_tdata[2*SB+GAIN_W-1:2*SB];
      mg_r   <= in_tdata[2*SB+2*GAIN_W-1:2*SB+GAIN_W];
      lg_r   <= in_tdata[2*SB+3*GAIN_W-1:2*SB+2*GAIN_W];
    end
  end

  // state memory, row = {bp right, lp right, bp left, lp left}
  always_ff @(posedge clk) begin
    if (cmd.take) rd_r <= mem[rd_slot];
    if (cmd.op == OP_STORE) mem[slot_r] <= {bp_rt, lp_rt, bp_l, lp_l};
  end

  // row valid bits, an unwritten row reads as zero state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.take) rd_valid_r <= valid_r[rd_slot];
      if (cmd.op == OP_STORE) valid_r[slot_r] <= 1'b1;
    end
  end

  assign rd_row = rd_valid_r ? rd_r : '0;

  sveq_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk       (clk),
    .cmd       (cmd),
    .coef      (coef),
    .x         (xl_r),
    .high_gain (hg_r),
    .mid_gain  (mg_r),
    .low_gain  (lg_r),
    .lp_init   (rd_row[STATE_W-1:0]),
    .bp_init   (rd_row[2*STATE_W-1:STATE_W]),
    .lp_q      (lp_l),
    .bp_q      (bp_l),
    .y         (y_l)
  );

  sveq_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk       (clk),
    .cmd       (cmd),
    .coef      (coef),
    .x         (xr_r),
    .high_gain (hg_r),
    .mid_gain  (mg_r),
    .low_gain  (lg_r),
    .lp_init   (rd_row[3*STATE_W-1:2*STATE_W]),
    .bp_init   (rd_row[4*STATE_W-1:3*STATE_W]),
    .lp_q      (lp_rt),
    .bp_q      (bp_rt),
    .y         (y_rt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      out_ch_r <= ch_r;
      out_l_r  <= y_l;
      out_rt_r <= y_rt;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tuser       = out_ch_r;
  assign out_tdata       = OUT_DW'({out_rt_r, out_l_r});

endmodule

>>> rtl/stereo_svf_three_band_eq.sv
// top level of the stereo three-band state-variable equalizer
// depends on sveq_pkg, sveq_ctrl, sveq_datapath and assert_macros.svh
//
// channel   | dir | handshake                    | contents
// ----------+-----+------------------------------+-----------------------------------------
// in_       | in  | in_tvalid / in_tready        | tuser channel, tdata samples and gains
// out_      | out | out_tvalid / out_tready      | tuser channel, tdata equalized samples
// cfg_      | in  | cfg_psel / cfg_penable       | freq_coef at byte address 0
//
// one word is processed at a time; an accepted word passes through a load step,
// three five-step filter passes on the single coefficient multiplier
// per side, eight steps of store, weighting, rounding, clamping and divide, and a finish step
// reset is synchronous; state rows read as zero until first written, so no clearing pass
// a stalled output register holds the sequencer in its last step; the next input
// word is accepted once the result has moved into the output register
`include "assert_macros.svh"

module stereo_svf_three_band_eq
  import sveq_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input words
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [CH_W-1:0]         in_tuser,   // channel
  // left_in, right_in, high_gain, mid_gain, low_gain, zero fill
  input  logic [((2*SAMPLE_BITS+3*GAIN_W+7)/8)*8-1:0] in_tdata,
  // result words
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [CH_W-1:0]         out_tuser,  // channel_out
  // left_out, right_out, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // configuration
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]   cfg_prdata,
  output logic                    cfg_pready
);

  logic [COEF_W-1:0] coef_r;
  logic              cfg_wr;
  sveq_cmd_t         cmd;
  sveq_status_t      status;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_FREQ_COEF)) begin
      coef_r <= cfg_pwdata[COEF_W-1:0];
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_FREQ_COEF: cfg_prdata = CFG_DATA_W'(coef_r);
      default:       cfg_prdata = '0;
    endcase
  end

  sveq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sveq_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .coef       (coef_r),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // checks
  `SVEQ_ASSERT_NEXT(a_accept_loads, in_tvalid && in_tready, cmd.op == OP_LOAD, "accepted word not loaded")
  `SVEQ_ASSERT_SAME(a_out_from_fin, $rose(out_tvalid), $past(cmd.op) == OP_FIN, "result without finish step")
  `SVEQ_ASSERT_SAME(a_fin_no_overrun, cmd.op == OP_FIN, !out_tvalid || out_tready, "result overwrote a held word")
  `SVEQ_ASSERT_SAME(a_ready_only_idle, in_tready, cmd.op == OP_NONE, "input taken while busy")

endmodule

>>> tb/tb.sv
// testbench for stereo_svf_three_band_eq: directed rows, then random words under several coefficients
// results are checked against a bench filter model or a typed row; needs sveq_pkg and the rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sveq_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int NCH          = CHANNELS_DEF;
  localparam int IN_W         = ((2*SB+3*GAIN_W+7)/8)*8;
  localparam int OUT_W        = ((2*SB+7)/8)*8;
  localparam int PHASE_WORDS  = 290;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 5000;
  localparam logic [CFG_ADDR_W-1:0] COEF_ADDR  = {REG_FREQ_COEF, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB-1)) - 1;
  localparam longint SAMPLE_MIN = -(64'sd1 <<< (SB-1));
  localparam longint STATE_MAX  = 64'sd2147483647;
  localparam longint STATE_MIN  = -64'sd2147483648;
  localparam longint GAIN_ONE   = 64'sd1 <<< AVG_SHIFT;
  localparam longint GAIN_TOP   = (64'sd1 <<< GAIN_W) - 1;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [SB-1:0]     left;
    logic signed [SB-1:0]     right;
    logic [GAIN_W-1:0]        hg;
    logic [GAIN_W-1:0]        mg;
    logic [GAIN_W-1:0]        lg;
  } eq_in_t;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [SB-1:0]     left;
    logic signed [SB-1:0]     right;
  } eq_out_t;

  typedef struct packed {
    eq_in_t  word;
    logic    typed;   // result below is fixed by hand
    eq_out_t res;
  } eq_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CH_W-1:0]       in_tuser;   // channel
  logic [IN_W-1:0]       in_tdata;   // left_in, right_in, high_gain, mid_gain, low_gain, zero fill
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CH_W-1:0]       out_tuser;  // channel_out
  logic [OUT_W-1:0]      out_tdata;  // left_out, right_out
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // filter model state and expected result words
  logic signed [STATE_W-1:0] low_mem  [NCH*2];
  logic signed [STATE_W-1:0] band_mem [NCH*2];
  logic [COEF_W-1:0]         coef_now;
  eq_out_t                   results_due[$];
  int                        err_cnt = 0;
  logic                      send_calm = 1'b0;

  stereo_svf_three_band_eq dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_quot(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint sat_state(longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  // Q0.24 coefficient times state, round half up
  function automatic longint coef_scale(longint v);
    return floor_quot(longint'(coef_now) * v + (64'sd1 <<< (ROUND_SHIFT-1)),
                      64'sd1 <<< ROUND_SHIFT);
  endfunction

  // three filter passes on one side, then weighted one-third average
  function automatic logic signed [SB-1:0] eq_side(int idx, longint x, longint hg,
                                                   longint mg, longint lg);
    longint lp, bp, hp, sum_lo, sum_band, sum_hi, r;
    int p;
    lp = low_mem[idx];
    bp = band_mem[idx];
    sum_lo = 0;
    sum_band = 0;
    sum_hi = 0;
    for (p = 0; p < 3; p++) begin
      lp = sat_state(lp + coef_scale(bp));
      hp = sat_state(x - lp - bp);
      bp = sat_state(bp + coef_scale(hp));
      sum_lo += lp;
      sum_band += bp;
      sum_hi += hp;
    end
    low_mem[idx]  = lp[STATE_W-1:0];
    band_mem[idx] = bp[STATE_W-1:0];
    r = floor_quot(sum_hi*hg + sum_band*mg + sum_lo*lg + AVG_HALF, 3*GAIN_ONE);
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    return r[SB-1:0];
  endfunction

  function automatic eq_out_t equalize_word(eq_in_t w);
    eq_out_t res;
    int slot;
    slot = (int'(w.ch) % NCH) * 2;
    res.ch    = w.ch;
    res.left  = eq_side(slot,     longint'($signed(w.left)),  w.hg, w.mg, w.lg);
    res.right = eq_side(slot + 1, longint'($signed(w.right)), w.hg, w.mg, w.lg);
    return res;
  endfunction

  function automatic void note_mismatch(string what, longint want, longint got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  function automatic eq_row_t dir_row(int ch, longint l, longint r, longint hg, longint mg,
                                      longint lg, bit typed, longint el, longint er);
    eq_row_t row;
    row.word.ch    = ch[CH_W-1:0];
    row.word.left  = l[SB-1:0];
    row.word.right = r[SB-1:0];
    row.word.hg    = hg[GAIN_W-1:0];
    row.word.mg    = mg[GAIN_W-1:0];
    row.word.lg    = lg[GAIN_W-1:0];
    row.typed      = typed;
    row.res.ch     = ch[CH_W-1:0];
    row.res.left   = el[SB-1:0];
    row.res.right  = er[SB-1:0];
    return row;
  endfunction

  // random, small, full scale, or the previous sample held
  function automatic logic signed [SB-1:0] rand_sample(logic signed [SB-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SB'($urandom);
      4, 5:       return SB'(int'($urandom_range(0, 4095)) - 2048);
      6:          return SB'(SAMPLE_MAX);
      7:          return SB'(SAMPLE_MIN);
      default:    return prev;
    endcase
  endfunction

  // gains mostly up to unity, some zero, unity or above unity
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return GAIN_W'(GAIN_ONE);
      2:       return GAIN_W'($urandom_range(0, GAIN_TOP));
      default: return GAIN_W'($urandom_range(0, GAIN_ONE));
    endcase
  endfunction

  // one apb transfer, setup then access
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rd);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    if (wr && addr == COEF_ADDR) coef_now = data[COEF_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // send one input word after a random gap, predict on acceptance
  task automatic send_word(input eq_row_t row);
    int gap;
    eq_out_t pred;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.word.ch;
    in_tdata  <= IN_W'({row.word.lg, row.word.mg, row.word.hg, row.word.right, row.word.left});
    do @(posedge clk); while (!in_tready);
    pred = equalize_word(row.word);
    results_due.push_back(row.typed ? row.res : pred);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (results_due.size() != 0 && n < IDLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, compare each word with the oldest expectation
  initial begin : result_check
    eq_out_t want;
    int stall;
    logic recv_calm;
    recv_calm = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (results_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("result word for channel %0d with none expected", out_tuser);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.ch) note_mismatch("channel", want.ch, out_tuser);
        if (out_tdata[SB-1:0] !== want.left)
          note_mismatch("left", want.left, $signed(out_tdata[SB-1:0]));
        if (out_tdata[2*SB-1:SB] !== want.right)
          note_mismatch("right", want.right, $signed(out_tdata[2*SB-1:SB]));
      end
    end
  end

  // stimulus: directed rows, then random phases over several coefficients
  initial begin : stimulus
    eq_row_t dir_rows[$];
    eq_row_t row;
    logic [CFG_DATA_W-1:0] rd;
    logic [COEF_W-1:0] coef_plan[6];
    logic signed [SB-1:0] last_left, last_right;
    int ph, k;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= '0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    coef_now = COEF_RESET;
    for (k = 0; k < NCH*2; k++) begin
      low_mem[k]  = '0;
      band_mem[k] = '0;
    end
    last_left  = '0;
    last_right = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, COEF_ADDR, '0, rd);
    if (rd[COEF_W-1:0] !== COEF_RESET) note_mismatch("freq_coef at reset", COEF_RESET, rd);

    // zero input on fresh state, full-scale saturation, zero gains, then model-checked rows
    dir_rows.push_back(dir_row(0, 0, 0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 1'b1, 0, 0));
    dir_rows.push_back(dir_row(31, SAMPLE_MAX, SAMPLE_MIN, GAIN_TOP, 0, 0,
                               1'b1, SAMPLE_MAX, SAMPLE_MIN));
    dir_rows.push_back(dir_row(5, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0, 1'b1, 0, 0));
    dir_rows.push_back(dir_row(31, SAMPLE_MIN, SAMPLE_MAX, GAIN_ONE, GAIN_ONE, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(31, SAMPLE_MIN, SAMPLE_MAX, GAIN_ONE, GAIN_ONE, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(0, SAMPLE_MAX, SAMPLE_MAX, 0, 0, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(0, SAMPLE_MAX, SAMPLE_MAX, 0, GAIN_ONE, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, SAMPLE_MAX, SAMPLE_MAX, GAIN_ONE, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, 1, -1, GAIN_ONE, GAIN_ONE, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(2, 5592405, -5592406, 87381, 43690, GAIN_TOP, 0, 0, 0));
    dir_rows.push_back(dir_row(2, -5592406, 5592405, 43690, 87381, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(16, SAMPLE_MAX, SAMPLE_MIN, GAIN_TOP, GAIN_TOP, GAIN_TOP, 0, 0, 0));
    dir_rows.push_back(dir_row(16, 0, 0, GAIN_TOP, GAIN_TOP, GAIN_TOP, 0, 0, 0));
    dir_rows.push_back(dir_row(5, 0, 0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 0, 0, 0));
    dir_rows.push_back(dir_row(15, -1, 0, 0, GAIN_ONE, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(31, 0, 0, 0, 0, GAIN_ONE, 0, 0, 0));
    for (k = 0; k < dir_rows.size(); k++) send_word(dir_rows[k]);
    in_tvalid <= 1'b0;
    wait_drained();

    // random words, coefficient extremes first, reset value last
    coef_plan = '{24'd0, 24'hFFFFFF, 24'd1, 24'h800000, 24'd0, COEF_RESET};
    coef_plan[4] = COEF_W'($urandom);
    for (ph = 0; ph < 6; ph++) begin
      cfg_access(1'b1, COEF_ADDR, CFG_DATA_W'(coef_plan[ph]), rd);
      // a write to the unused address must leave the coefficient alone
      if (ph == 5) cfg_access(1'b1, SPARE_ADDR, $urandom, rd);
      cfg_access(1'b0, COEF_ADDR, '0, rd);
      if (rd[COEF_W-1:0] !== coef_now) note_mismatch("freq_coef readback", coef_now, rd);
      for (k = 0; k < PHASE_WORDS; k++) begin
        row = '0;
        // favor a few channels so their filter states run long
        row.word.ch = ($urandom_range(0, 1) == 0) ? CH_W'($urandom_range(0, 3))
                                                  : CH_W'($urandom_range(0, NCH-1));
        last_left  = rand_sample(last_left);
        last_right = rand_sample(last_right);
        row.word.left  = last_left;
        row.word.right = last_right;
        row.word.hg = rand_gain();
        row.word.mg = rand_gain();
        row.word.lg = rand_gain();
        send_word(row);
      end
      in_tvalid <= 1'b0;
      wait_drained();
    end

    if (results_due.size() != 0) begin
      err_cnt++;
      $display("%0d expected result words never arrived", results_due.size());
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
